FILE: hdl/ltd_pkg.sv
// Package for the LZ77 token decoder: shared widths, codes and the sequencer states.
// It depends on nothing. ltd_hist_ram and lz77_token_decoder import it.
package ltd_pkg;

    localparam int CODE_W      = 16;   // code word width
    localparam int BYTE_W      = 8;    // data byte width
    localparam int LEN_W       = 7;    // held match length width
    localparam int LITERAL_MAX = 255;  // largest literal code

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_READ,
        S_LOAD,
        S_OUT
    } t_state;

endpackage

FILE: hdl/ltd_hist_ram.sv
// Circular history store for the LZ77 token decoder: one write port and one registered read port.
// It uses BYTE_W from ltd_pkg.
module ltd_hist_ram
    import ltd_pkg::*;
#(
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = 16
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [BYTE_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [BYTE_W-1:0] o_rdata
);

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/lz77_token_decoder.sv
// LZ77 token decoder top level: sequencer, pointers, match check and output register.
// It uses ltd_pkg and instantiates ltd_hist_ram for the circular history.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+--------------------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_code_word[15:0]
//  out     | output    | o_out_valid / i_out_ready  | o_out_byte[7:0], o_run_last, o_bad_token
//
// Literal: accepted, then the result waits in the output register until taken.
// Length token: accepted with no result. Distance: accepted, then the match check,
// then per copied byte a history read, load/write-back and output, plus any output stall.
// The registered history read and the output handshake set these steps per copied byte.
// Synchronous active-low reset clears the write pointer, the fill count and the token state;
// the history itself is not cleared. Input is taken only while the sequencer is idle.
module lz77_token_decoder
    import ltd_pkg::*;
#(
    parameter int HISTORY_DEPTH = 65536,
    parameter int LENGTH_BASE   = 256,
    parameter int MAX_MATCH     = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [CODE_W-1:0] i_code_word,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_run_last,
    output logic              o_bad_token
);

    localparam int PTR_W  = $clog2(HISTORY_DEPTH);
    localparam int BW_W   = $clog2(HISTORY_DEPTH + 1);
    localparam int CMP_W  = (BW_W > CODE_W) ? BW_W : CODE_W;
    localparam int SUM_W  = CMP_W + 1;
    localparam int WORD_W = CODE_W + 1;
    localparam int LEN_LO = LENGTH_BASE + 1;
    localparam int LEN_HI = LENGTH_BASE + MAX_MATCH;

    t_state             r_state, n_state;
    logic [PTR_W-1:0]   r_wp, n_wp;
    logic [BW_W-1:0]    r_bw, n_bw;
    logic               r_await, n_await;
    logic [LEN_W-1:0]   r_plen, n_plen;
    logic [CODE_W-1:0]  r_dist, n_dist;
    logic [PTR_W-1:0]   r_src, n_src;
    logic [LEN_W-1:0]   r_remain, n_remain;
    logic               r_out_valid, n_out_valid;
    logic [BYTE_W-1:0]  r_out_byte, n_out_byte;
    logic               r_last, n_last;
    logic               r_bad, n_bad;

    logic               ram_we;
    logic [BYTE_W-1:0]  ram_wdata;
    logic [BYTE_W-1:0]  ram_rdata;

    logic [PTR_W-1:0]   wp_inc, src_inc;
    logic [BW_W-1:0]    bw_inc;
    logic               is_literal, len_ok;
    logic [WORD_W-1:0]  word_x, len_diff;
    logic [CMP_W-1:0]   dist_x, bw_x;
    logic               dist_bad;
    logic [SUM_W-1:0]   wp_s, dist_s, src_sum;

    ltd_hist_ram #(
        .DEPTH  (HISTORY_DEPTH),
        .ADDR_W (PTR_W)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (ram_wdata),
        .i_raddr (r_src),
        .o_rdata (ram_rdata)
    );

    // pointer and count arithmetic
    assign wp_inc  = (r_wp == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign src_inc = (r_src == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : r_src + 1'b1;
    assign bw_inc  = (r_bw == BW_W'(HISTORY_DEPTH)) ? r_bw : r_bw + 1'b1;

    // token decode
    assign is_literal = (i_code_word <= CODE_W'(LITERAL_MAX));
    assign word_x     = WORD_W'(i_code_word);
    assign len_ok     = (word_x >= WORD_W'(LEN_LO)) && (word_x <= WORD_W'(LEN_HI));
    assign len_diff   = word_x - WORD_W'(LENGTH_BASE);

    // match check and start address, wrapping backwards round the history
    assign dist_x   = CMP_W'(r_dist);
    assign bw_x     = CMP_W'(r_bw);
    assign dist_bad = (r_plen == '0) || (r_dist == '0) || (dist_x > bw_x);
    assign wp_s     = SUM_W'(r_wp);
    assign dist_s   = SUM_W'(r_dist);
    assign src_sum  = wp_s + ((wp_s >= dist_s) ? '0 : SUM_W'(HISTORY_DEPTH)) - dist_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_bw        <= '0;
            r_await     <= 1'b0;
            r_plen      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_bw        <= n_bw;
            r_await     <= n_await;
            r_plen      <= n_plen;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dist     <= n_dist;
        r_src      <= n_src;
        r_remain   <= n_remain;
        r_out_byte <= n_out_byte;
        r_last     <= n_last;
        r_bad      <= n_bad;
    end

    always_comb begin
        n_state     = r_state;
        n_wp        = r_wp;
        n_bw        = r_bw;
        n_await     = r_await;
        n_plen      = r_plen;
        n_dist      = r_dist;
        n_src       = r_src;
        n_remain    = r_remain;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_last      = r_last;
        n_bad       = r_bad;
        ram_we      = 1'b0;
        ram_wdata   = ram_rdata;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (r_await) begin
                        n_await = 1'b0;
                        n_dist  = i_code_word;
                        n_state = S_CHECK;
                    end else if (is_literal) begin
                        ram_we      = 1'b1;
                        ram_wdata   = i_code_word[BYTE_W-1:0];
                        n_wp        = wp_inc;
                        n_bw        = bw_inc;
                        n_out_byte  = i_code_word[BYTE_W-1:0];
                        n_last      = 1'b1;
                        n_bad       = 1'b0;
                        n_out_valid = 1'b1;
                        n_state     = S_OUT;
                    end else begin
                        // length token: an out-of-range length is held as zero
                        n_await = 1'b1;
                        n_plen  = len_ok ? len_diff[LEN_W-1:0] : '0;
                    end
                end
            end
            S_CHECK: begin
                n_plen = '0;
                if (dist_bad) begin
                    n_out_byte  = '0;
                    n_last      = 1'b1;
                    n_bad       = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_OUT;
                end else begin
                    n_src    = src_sum[PTR_W-1:0];
                    n_remain = r_plen;
                    n_state  = S_READ;
                end
            end
            S_READ: begin
                // read data lands next cycle; the previous byte is already written
                n_state = S_LOAD;
            end
            S_LOAD: begin
                ram_we      = 1'b1;
                ram_wdata   = ram_rdata;
                n_wp        = wp_inc;
                n_bw        = bw_inc;
                n_src       = src_inc;
                n_remain    = r_remain - 1'b1;
                n_out_byte  = ram_rdata;
                n_last      = (r_remain == LEN_W'(1));
                n_bad       = 1'b0;
                n_out_valid = 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_out_valid = 1'b0;
                    n_state     = r_last ? S_IDLE : S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_run_last  = r_last;
    assign o_bad_token = r_bad;

    a_bad_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_bad_token) |-> (o_out_byte == '0) && o_run_last)
        else $error("error item without zero byte or last mark");

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input taken while a result is pending");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bw <= BW_W'(HISTORY_DEPTH)) && (r_wp <= PTR_W'(HISTORY_DEPTH - 1)))
        else $error("history pointer or fill count out of range");

    a_copy_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_remain != '0))
        else $error("copy step with no bytes left");

    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_run_last) |=> (r_state == S_IDLE))
        else $error("sequencer busy after last item of a run");

endmodule

FILE: tb/lz77_token_decoder_tb.sv
// Self-checking testbench for lz77_token_decoder: directed token table, then random streams.
// Depends on ltd_pkg and lz77_token_decoder; predicts the byte stream with its own history copy.
`timescale 1ns / 1ps

module lz77_token_decoder_tb;
    import ltd_pkg::*;

    localparam int HIST_DEPTH = 65536;
    localparam int LEN_BASE   = 256;
    localparam int MATCH_MAX  = 64;
    localparam int DIR_ROWS   = 23;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              is_last;
        logic              bad;
    } t_out;

    // how a directed row is checked: by the predictor or by a value typed in here
    typedef enum logic [1:0] {
        ROW_PRED,
        ROW_LIT,
        ROW_BAD
    } t_row_kind;

    localparam t_out BAD_RES = '{data: '0, is_last: 1'b1, bad: 1'b1};

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_ready;
    logic [CODE_W-1:0] i_code_word = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [BYTE_W-1:0] o_out_byte;
    logic              o_run_last;
    logic              o_bad_token;

    // predictor state
    logic [BYTE_W-1:0] hist_mem [0:HIST_DEPTH-1];
    int unsigned       wr_ptr    = 0;
    int unsigned       fill_cnt  = 0;
    bit                wait_dist = 1'b0;
    logic [LEN_W-1:0]  held_len  = '0;

    t_out pred_q [$];
    t_out byte_q [$];
    int   n_errors   = 0;
    int   n_sent     = 0;
    bit   in_quiet   = 1'b0;
    bit   out_quiet  = 1'b0;
    int   stall_left = 0;
    int   n_cycles   = 0;

    logic [CODE_W-1:0] dir_word [0:DIR_ROWS-1] = '{
        16'(LEN_BASE + 1),             16'd1,           // copy with nothing stored yet
        16'd0,                         16'(LITERAL_MAX),
        16'd165,
        16'(LEN_BASE + 3),             16'd1,           // overlapping run of one byte
        16'(LEN_BASE + MATCH_MAX),     16'd2,           // longest match
        16'(LEN_BASE + MATCH_MAX + 1), 16'd1,           // length one too long
        16'(LEN_BASE),                 16'd1,           // length zero
        16'(LEN_BASE + 1),             16'd0,           // distance zero
        16'(LEN_BASE + 2),             16'hFFFF,        // distance past stored bytes
        16'hFFFF,                      16'hFFFF,        // oversized token, then its distance
        16'(LEN_BASE + 2),             16'd70,          // distance equal to bytes stored
        16'(LEN_BASE + 1),             16'd73           // one past bytes stored
    };

    t_row_kind dir_kind [0:DIR_ROWS-1] = '{
        ROW_PRED, ROW_BAD,
        ROW_LIT,  ROW_LIT,
        ROW_LIT,
        ROW_PRED, ROW_PRED,
        ROW_PRED, ROW_PRED,
        ROW_PRED, ROW_BAD,
        ROW_PRED, ROW_BAD,
        ROW_PRED, ROW_BAD,
        ROW_PRED, ROW_BAD,
        ROW_PRED, ROW_BAD,
        ROW_PRED, ROW_PRED,
        ROW_PRED, ROW_BAD
    };

    lz77_token_decoder #(
        .HISTORY_DEPTH (HIST_DEPTH),
        .LENGTH_BASE   (LEN_BASE),
        .MAX_MATCH     (MATCH_MAX)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_code_word (i_code_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_run_last  (o_run_last),
        .o_bad_token (o_bad_token)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic keep_byte(input logic [BYTE_W-1:0] b);
        hist_mem[wr_ptr] = b;
        wr_ptr = (wr_ptr + 1) % HIST_DEPTH;
        if (fill_cnt < HIST_DEPTH) begin
            fill_cnt++;
        end
    endtask

    // bytes produced by one code word, left in pred_q
    task automatic decode_word(input logic [CODE_W-1:0] w);
        int unsigned src;
        int unsigned len;
        logic [BYTE_W-1:0] b;
        pred_q.delete();
        if (wait_dist) begin
            wait_dist = 1'b0;
            len       = held_len;
            held_len  = '0;
            if (len == 0 || w == 0 || w > fill_cnt) begin
                pred_q.insert(pred_q.size(), BAD_RES);
            end else begin
                src = (wr_ptr + HIST_DEPTH - w) % HIST_DEPTH;
                for (int i = 0; i < len; i++) begin
                    b = hist_mem[src];
                    keep_byte(b);
                    src = (src + 1) % HIST_DEPTH;
                    pred_q.insert(pred_q.size(), t_out'{b, (i == len - 1), 1'b0});
                end
            end
        end else if (w <= LITERAL_MAX) begin
            keep_byte(w[BYTE_W-1:0]);
            pred_q.insert(pred_q.size(), t_out'{w[BYTE_W-1:0], 1'b1, 1'b0});
        end else begin
            wait_dist = 1'b1;
            held_len  = '0;
            if (w >= LEN_BASE && w - LEN_BASE >= 1 && w - LEN_BASE <= MATCH_MAX) begin
                held_len = LEN_W'(w - LEN_BASE);
            end
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (in_quiet || r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 40);
    endfunction

    task automatic send_word(input logic [CODE_W-1:0] w, input t_row_kind kind);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
        @(negedge i_clk);
        i_in_valid  = 1'b1;
        i_code_word = w;
        do @(posedge i_clk); while (!o_in_ready);
        decode_word(w);
        case (kind)
            ROW_LIT: byte_q.insert(byte_q.size(), t_out'{w[BYTE_W-1:0], 1'b1, 1'b0});
            ROW_BAD: byte_q.insert(byte_q.size(), BAD_RES);
            default: begin
                foreach (pred_q[k]) byte_q.insert(byte_q.size(), pred_q[k]);
            end
        endcase
        n_sent++;
        if (n_sent % 64 == 0) begin
            in_quiet = ($urandom_range(0, 3) == 0);
        end
    endtask

    function automatic logic [CODE_W-1:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            return CODE_W'(LEN_BASE + $urandom_range(1, 8));
        end else if (r < 90) begin
            return CODE_W'(LEN_BASE + $urandom_range(9, MATCH_MAX));
        end
        return CODE_W'(LEN_BASE + MATCH_MAX);
    endfunction

    // a distance inside what has been stored (1 while nothing is stored); deep reaches back across the whole history
    function automatic logic [CODE_W-1:0] pick_dist(input bit deep);
        int unsigned reach;
        int r;
        reach = (fill_cnt > 65535) ? 65535 : fill_cnt;
        r = $urandom_range(0, 99);
        if (reach == 0) begin
            return 16'd1;
        end else if (deep && r < 8) begin
            return CODE_W'(reach);
        end else if (deep && r < 35) begin
            return CODE_W'($urandom_range(1, reach));
        end
        return CODE_W'($urandom_range(1, (reach < 16) ? reach : 16));
    endfunction

    task automatic run_random(input int n_items, input bit deep);
        int r;
        int unsigned reach;
        for (int n = 0; n < n_items; n++) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                send_word(CODE_W'($urandom_range(0, LITERAL_MAX)), ROW_PRED);
            end else if (r < 85) begin
                send_word(pick_len(), ROW_PRED);
                send_word(pick_dist(deep), ROW_PRED);
            end else if (r < 89) begin
                // length zero or too long, random distance
                send_word($urandom_range(0, 1) ? CODE_W'(LEN_BASE)
                          : CODE_W'($urandom_range(LEN_BASE + MATCH_MAX + 1, 65535)), ROW_PRED);
                send_word(CODE_W'($urandom_range(0, 65535)), ROW_PRED);
            end else if (r < 93) begin
                send_word(pick_len(), ROW_PRED);
                reach = fill_cnt;
                if (reach < 65535 && $urandom_range(0, 1)) begin
                    send_word(CODE_W'($urandom_range(reach + 1, 65535)), ROW_PRED);
                end else begin
                    send_word(16'd0, ROW_PRED);
                end
            end else begin
                send_word(CODE_W'($urandom_range(0, 65535)), ROW_PRED);
            end
        end
    endtask

    // receiver back-pressure, mostly short stalls, now and then a quiet stretch
    initial begin
        forever begin
            @(negedge i_clk);
            n_cycles++;
            if (n_cycles % 256 == 0) begin
                out_quiet = ($urandom_range(0, 3) == 0);
            end
            if (stall_left > 0) begin
                i_out_ready = 1'b0;
                stall_left--;
            end else begin
                i_out_ready = 1'b1;
                if (!out_quiet) begin
                    if ($urandom_range(0, 99) < 20) begin
                        stall_left = $urandom_range(1, 3);
                    end else if ($urandom_range(0, 99) < 3) begin
                        stall_left = $urandom_range(4, 40);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (byte_q.size() == 0) begin
                $display("%0t: unexpected item, byte %0d last %0b bad %0b",
                         $time, o_out_byte, o_run_last, o_bad_token);
                n_errors++;
            end else begin
                want = byte_q.pop_front();
                if (o_out_byte !== want.data) begin
                    $display("%0t: out_byte expected %0d got %0d", $time, want.data, o_out_byte);
                    n_errors++;
                end
                if (o_run_last !== want.is_last) begin
                    $display("%0t: run_last expected %0b got %0b",
                             $time, want.is_last, o_run_last);
                    n_errors++;
                end
                if (o_bad_token !== want.bad) begin
                    $display("%0t: bad_token expected %0b got %0b", $time, want.bad, o_bad_token);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            send_word(dir_word[i], dir_kind[i]);
        end

        run_random(140, 1'b0);

        // long matches to build up a deeper history for far-reaching distances
        for (int i = 0; i < 40; i++) begin
            send_word(CODE_W'(LEN_BASE + MATCH_MAX), ROW_PRED);
            send_word(CODE_W'($urandom_range(1, (fill_cnt < 300) ? fill_cnt : 300)), ROW_PRED);
        end

        run_random(60, 1'b1);

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (byte_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        if (n_errors == 0 && byte_q.size() == 0) begin
            $display("lz77_token_decoder_tb passed");
        end else begin
            $display("lz77_token_decoder_tb failed");
        end
        $finish;
    end

    initial begin
        #120_000_000;
        $display("lz77_token_decoder_tb failed");
        $finish;
    end

endmodule
